FILE: hw/rtl/lcsa_pkg.sv
package lcsa_pkg;

    // Default depth of the cell row.
    localparam int MaxEntries = 16;

    // Width of the capacity register and its value after reset.
    localparam int CapWidth = 5;
    localparam logic [CapWidth-1:0] CapResetValue = 5'd16;

    // Operation codes.
    localparam logic CmdGet = 1'b0;
    localparam logic CmdPut = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] key;
        logic signed [31:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic signed [31:0] read_value;
    } t_out_item;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic        compare;     // latch the match flag for cmp_key
        logic [31:0] cmp_key;
        logic        update;      // apply the shift / load for the held beat
        logic        evict;       // a new key pushes out position 0
        logic        write_en;    // some cell takes the load data
        logic        append;      // the load lands one above the current top
        logic [31:0] load_key;
        logic [31:0] load_value;
    } t_cell_ctrl;

    // Passed from each cell to the one above it.
    typedef struct packed {
        logic        hit_seen;    // a match at or below this position
        logic [31:0] hit_value;   // value of that matching entry
    } t_cell_chain;

endpackage

FILE: hw/rtl/lcsa_cell.sv
module lcsa_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic                 i_clk,
    input  lcsa_pkg::t_cell_ctrl i_ctrl,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [31:0]          i_above_key,
    input  logic [31:0]          i_above_value,
    input  lcsa_pkg::t_cell_chain i_chain,
    output lcsa_pkg::t_cell_chain o_chain,
    output logic [31:0]          o_key,
    output logic [31:0]          o_value,
    output logic                 o_match
);

    logic [31:0] r_key;
    logic [31:0] r_value;
    logic        r_match;

    logic        valid;
    logic        above_valid;
    logic        shift;
    logic        load_here;

    // This position holds an entry when it sits below the count.
    assign valid       = CNT_W'(IDX) < i_count;
    assign above_valid = CNT_W'(IDX + 1) < i_count;

    // Shift down when a hit lies at or below this cell (or on eviction) and
    // the cell above still holds an entry.
    assign shift = (i_chain.hit_seen | r_match | i_ctrl.evict) & above_valid;

    assign load_here = i_ctrl.write_en &
                       (i_ctrl.append ? (CNT_W'(IDX) == i_count)
                                      : (CNT_W'(IDX + 1) == i_count));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.compare) begin
            r_match <= valid & (r_key == i_ctrl.cmp_key);
        end
        if (i_ctrl.update) begin
            if (load_here) begin
                r_key   <= i_ctrl.load_key;
                r_value <= i_ctrl.load_value;
            end else if (shift) begin
                r_key   <= i_above_key;
                r_value <= i_above_value;
            end
        end
    end

    always_comb begin
        o_chain.hit_seen  = i_chain.hit_seen | r_match;
        o_chain.hit_value = r_match ? r_value : i_chain.hit_value;
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_match = r_match;

endmodule

FILE: hw/rtl/lru_cache_shift_array.sv
// LRU key-value store built as a row of cells in recency order.
// Cell 0 holds the least recently used entry; the newest entry sits at
// position count-1. Each beat on the input channel is a get or a put.
// Input channel: i_in_valid / o_in_stall / i_in_data. A beat is taken at a
// clock edge where valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall / o_out_data, one result beat per
// input beat, in order. The result reports whether the key was present and,
// for a get that hits, the stored value.
// Timing: each item has a compare phase and an update phase. In the compare
// phase every cell compares its key against the request and registers a
// match flag. In the update phase the match flags ripple up the row to find
// the hit, each cell takes its neighbor's entry or the load data, and the
// result goes into the output register. No new beat is taken during the
// update phase, nor while the result register is full and stalled.
// Configuration: a valid/ready write port sets the capacity in use; it is
// always ready and must only be written while the block is idle.
// Reset (synchronous, active low) empties the store, clears the output
// valid flag and restores a capacity of 16. A stalled result simply holds
// in the output register and back-pressures the input channel.
module lru_cache_shift_array #(
    parameter int MAX_ENTRIES = lcsa_pkg::MaxEntries
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  lcsa_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lcsa_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lcsa_pkg::CapWidth-1:0]   i_cfg_data
);

    localparam int CntW = $clog2(MAX_ENTRIES + 1);
    // Width wide enough for both the count and the capacity register.
    localparam int CmpW = (CntW > lcsa_pkg::CapWidth) ? CntW : lcsa_pkg::CapWidth;

    logic [CntW-1:0]                 r_count;
    logic [lcsa_pkg::CapWidth-1:0]   r_cap;
    logic                            r_busy;
    lcsa_pkg::t_in_item              r_item;
    logic                            r_out_valid;
    lcsa_pkg::t_out_item             r_out;

    lcsa_pkg::t_cell_ctrl            ctrl;
    lcsa_pkg::t_cell_chain           chain [MAX_ENTRIES+1];
    logic [31:0]                     cell_key   [MAX_ENTRIES+1];
    logic [31:0]                     cell_value [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0]          match_vec;

    logic                            in_accept;
    logic [CmpW-1:0]                 cap_eff;
    logic                            found;
    logic                            is_put;
    logic                            has_room;

    // The block holds one item at a time; the output register must be free
    // or draining before a new beat is taken.
    assign o_in_stall  = r_busy | (r_out_valid & i_out_stall);
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Effective capacity: zero acts as one, anything above the row depth as
    // the depth.
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CmpW'(1);
        end else if (CmpW'(r_cap) > CmpW'(MAX_ENTRIES)) begin
            cap_eff = CmpW'(MAX_ENTRIES);
        end else begin
            cap_eff = CmpW'(r_cap);
        end
    end

    assign found    = chain[MAX_ENTRIES].hit_seen;
    assign is_put   = (r_item.cmd == lcsa_pkg::CmdPut);
    assign has_room = CmpW'(r_count) < cap_eff;

    always_comb begin
        ctrl.compare    = in_accept;
        ctrl.cmp_key    = i_in_data.key;
        ctrl.update     = r_busy;
        ctrl.evict      = is_put & ~found & ~has_room;
        ctrl.write_en   = found | is_put;
        ctrl.append     = is_put & ~found & has_room;
        ctrl.load_key   = r_item.key;
        // A get hit moves the old value to the top unchanged.
        ctrl.load_value = is_put ? r_item.write_value : chain[MAX_ENTRIES].hit_value;
    end

    // Bottom of the row: no hit seen yet. Top of the row: nothing above.
    assign chain[0].hit_seen       = 1'b0;
    assign chain[0].hit_value      = '0;
    assign cell_key[MAX_ENTRIES]   = '0;
    assign cell_value[MAX_ENTRIES] = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lcsa_cell #(
            .CNT_W (CntW),
            .IDX   (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_count       (r_count),
            .i_above_key   (cell_key[g+1]),
            .i_above_value (cell_value[g+1]),
            .i_chain       (chain[g]),
            .o_chain       (chain[g+1]),
            .o_key         (cell_key[g]),
            .o_value       (cell_value[g]),
            .o_match       (match_vec[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= lcsa_pkg::CapResetValue;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            r_busy <= in_accept;
            if (r_busy) begin
                r_out_valid <= 1'b1;
                if (ctrl.append) begin
                    r_count <= r_count + CntW'(1);
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_data;
        end
        if (r_busy) begin
            r_out.found      <= found;
            r_out.read_value <= (found && !is_put) ? chain[MAX_ENTRIES].hit_value : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Keys among held entries are unique, so at most one cell matches.
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $onehot0(match_vec))
        else $error("more than one cell matched the key");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MAX_ENTRIES))
        else $error("entry count above row depth");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("entry count decreased");

    a_update_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy && o_out_valid)
        else $error("update phase did not finish in one cycle");

endmodule
